### sv/nsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg: shared types, constants and helpers
// Sentence phases, result kinds, character codes and the small character
// classifiers used by the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Default longest payload; the sentence may carry three more characters
  localparam int MAX_LEN_DEF = 80;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Scan phase within one sentence
  typedef enum logic [2:0] {
    PH_DOLLAR = 3'd0,
    PH_BODY   = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HEX2   = 3'd3,
    PH_TRAIL  = 3'd4,
    PH_CR     = 3'd5,
    PH_LF     = 3'd6,
    PH_ENDED  = 3'd7
  } phase_t;

  // Verdict codes
  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_UNKNOWN = 4'd1,
    KIND_RMC     = 4'd2,
    KIND_GGA     = 4'd3,
    KIND_GSA     = 4'd4,
    KIND_GLL     = 4'd5,
    KIND_GST     = 4'd6,
    KIND_GSV     = 4'd7,
    KIND_VTG     = 4'd8,
    KIND_ZDA     = 4'd9
  } kind_t;

  // One verdict
  typedef struct packed {
    kind_t      kind;
    logic       star;
    logic [7:0] xsum;
  } result_t;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Map identifier characters three to five to a sentence kind
  function automatic kind_t classify(input logic [23:0] id);
    kind_t k;
    k = KIND_UNKNOWN;
    if (id == "RMC") k = KIND_RMC;
    else if (id == "GGA") k = KIND_GGA;
    else if (id == "GSA") k = KIND_GSA;
    else if (id == "GLL") k = KIND_GLL;
    else if (id == "GST") k = KIND_GST;
    else if (id == "GSV") k = KIND_GSV;
    else if (id == "VTG") k = KIND_VTG;
    else if (id == "ZDA") k = KIND_ZDA;
    return k;
  endfunction

endpackage

### sv/nsc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_scan: per-byte sentence scanner
// Holds the sentence state, folds each accepted byte into it and forms the
// verdict on the final byte, then clears for the next sentence.
// ----------------------------------------------------------------------------
module nsc_scan #(
  parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             res_load,
  output nsc_pkg::result_t res
);

  localparam int CW = $clog2(MAX_LEN + 5);
  localparam logic [CW-1:0] CNT_SAT = CW'(MAX_LEN + 4);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEN + 3);
  localparam logic [CW-1:0] CNT_MIN = CW'(6);

  logic            strict_mode;
  nsc_pkg::phase_t phase, phase_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic [CW-1:0]   byte_count, byte_count_next;
  logic [7:0]      id_letters [3];
  logic [7:0]      id_letters_next [3];
  logic            id_ok, id_ok_next;
  logic            saw_star, saw_star_next;
  logic            failed, failed_next;
  logic [1:0]      pos_off;
  nsc_pkg::hex_t   hx;
  logic            ok;

  assign pos_off = 2'(byte_count - CW'(3));
  assign hx      = nsc_pkg::hex_digit(data_byte);

  // Fold one byte into the sentence state
  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    high_nibble_next = high_nibble;
    byte_count_next  = byte_count;
    id_letters_next  = id_letters;
    id_ok_next       = id_ok;
    saw_star_next    = saw_star;
    failed_next      = failed;
    if (phase != nsc_pkg::PH_ENDED) begin
      if (data_byte == nsc_pkg::CH_NUL) begin
        // NUL ends the text; invalid where more text is required
        if (phase == nsc_pkg::PH_DOLLAR || phase == nsc_pkg::PH_HEX1 ||
            phase == nsc_pkg::PH_HEX2 || phase == nsc_pkg::PH_CR) begin
          failed_next = 1'b1;
        end
        phase_next = nsc_pkg::PH_ENDED;
      end else begin
        if (byte_count < CNT_SAT) byte_count_next = byte_count + CW'(1);
        // Check identifier characters and keep the last three
        if (byte_count >= CW'(1) && byte_count <= CW'(5)) begin
          if (!nsc_pkg::is_printable(data_byte) || data_byte == nsc_pkg::CH_COMMA ||
              data_byte == nsc_pkg::CH_STAR) begin
            id_ok_next = 1'b0;
          end
          if (byte_count >= CW'(3)) id_letters_next[pos_off] = data_byte;
        end
        unique case (phase)
          nsc_pkg::PH_DOLLAR: begin
            if (data_byte == nsc_pkg::CH_DOLLAR) phase_next = nsc_pkg::PH_BODY;
            else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_BODY: begin
            if (data_byte == nsc_pkg::CH_STAR) begin
              saw_star_next = 1'b1;
              phase_next    = nsc_pkg::PH_HEX1;
            end else if (nsc_pkg::is_printable(data_byte)) begin
              running_xor_next = running_xor ^ data_byte;
            end else if (data_byte == nsc_pkg::CH_LF) begin
              phase_next = nsc_pkg::PH_LF;
            end else if (data_byte == nsc_pkg::CH_CR) begin
              phase_next = nsc_pkg::PH_CR;
            end else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_HEX1: begin
            if (hx.ok) begin
              high_nibble_next = hx.val;
              phase_next       = nsc_pkg::PH_HEX2;
            end else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_HEX2: begin
            if (hx.ok && {high_nibble, hx.val} == running_xor) begin
              phase_next = nsc_pkg::PH_TRAIL;
            end else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_TRAIL: begin
            if (data_byte == nsc_pkg::CH_LF) phase_next = nsc_pkg::PH_LF;
            else if (data_byte == nsc_pkg::CH_CR) phase_next = nsc_pkg::PH_CR;
            else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_CR: begin
            if (data_byte == nsc_pkg::CH_LF) phase_next = nsc_pkg::PH_LF;
            else begin
              failed_next = 1'b1;
              phase_next  = nsc_pkg::PH_ENDED;
            end
          end
          nsc_pkg::PH_LF, nsc_pkg::PH_ENDED: begin
            failed_next = 1'b1;
            phase_next  = nsc_pkg::PH_ENDED;
          end
        endcase
      end
    end
  end

  // Form the verdict from the state after this byte
  always_comb begin
    ok = !failed_next && id_ok_next && byte_count_next >= CNT_MIN &&
         byte_count_next <= CNT_MAX && phase_next != nsc_pkg::PH_HEX1 &&
         phase_next != nsc_pkg::PH_HEX2 && phase_next != nsc_pkg::PH_CR &&
         !(strict_mode && !saw_star_next);
    res.kind = ok ? nsc_pkg::classify({id_letters_next[0], id_letters_next[1],
                                       id_letters_next[2]})
                  : nsc_pkg::KIND_INVALID;
    res.star = saw_star_next;
    res.xsum = running_xor_next;
  end

  assign res_load = take && last_byte;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_mode <= cfg_wr_data;
    end
  end

  // Advance the sentence state; clear it after each verdict
  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase       <= nsc_pkg::PH_DOLLAR;
      running_xor <= 8'd0;
      high_nibble <= 4'd0;
      byte_count  <= '0;
      id_ok       <= 1'b1;
      saw_star    <= 1'b0;
      failed      <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      high_nibble <= high_nibble_next;
      byte_count  <= byte_count_next;
      id_ok       <= id_ok_next;
      saw_star    <= saw_star_next;
      failed      <= failed_next;
    end
  end

  // Identifier letters need no reset
  always_ff @(posedge clk) begin
    if (take) id_letters <= id_letters_next;
  end

endmodule

### sv/nsc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_out: verdict output register
// Holds one verdict until the receiver takes it and tells the input side
// whether a new byte can be taken this cycle.
// ----------------------------------------------------------------------------
module nsc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  nsc_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             space,
  output nsc_pkg::result_t held
);

  // Room when empty or when the held verdict leaves this cycle
  assign space = !out_valid || out_ready;

  // Track the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the verdict payload
  always_ff @(posedge clk) begin
    if (load) held <= res;
  end

endmodule

### sv/nmea_sentence_check_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_check_classify: NMEA sentence checker and classifier
// Checks framing, identifier, length and star checksum of each sentence and
// reports one verdict per sentence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one sentence byte per request, with
//   last_byte marking the final byte. A byte is taken every cycle while the
//   output side has room.
//   Output channel (out_valid/out_ready): one verdict request per sentence,
//   carrying sentence_kind, checksum_present and computed_xor.
//   The verdict is presented in the cycle after the final byte is accepted.
//   Throughput: one byte per cycle while the output side has room, set by
//   the single scan stage feeding the one-entry verdict register.
//   Configuration: cfg_wr_en writes cfg_wr_data into strict mode; write it
//   only between sentences. It is read on each sentence's final byte.
//   Reset: rst clears strict mode, the sentence state and the output valid.
//   Stall: while a verdict waits and out_ready is low, in_ready drops and
//   bytes hold at the input; with out_ready high a new byte enters in the
//   same cycle the waiting verdict leaves.
// ----------------------------------------------------------------------------
module nmea_sentence_check_classify #(
  parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] sentence_kind,
  output logic       checksum_present,
  output logic [7:0] computed_xor
);

  logic             take;
  logic             res_load;
  nsc_pkg::result_t res;
  nsc_pkg::result_t held;

  assign take = in_valid && in_ready;

  // Scan bytes and form verdicts
  nsc_scan #(
    .MAX_LEN(MAX_LEN)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .take       (take),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .res_load   (res_load),
    .res        (res)
  );

  // Hold verdicts for the receiver
  nsc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .space    (in_ready),
    .held     (held)
  );

  assign sentence_kind    = held.kind;
  assign checksum_present = held.star;
  assign computed_xor     = held.xsum;

endmodule

### tb/nmea_sentence_check_classify_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_check_classify_tb: self-checking bench for the sentence checker
// Streams NMEA sentences one character per request, most of them well formed
// with random content and some damaged or plain noise, under random idling on
// both channels. A scan model in the bench predicts each verdict, and every
// verdict that leaves the block is compared field by field in arrival order.
// Strict mode is switched between batches while the block is idle.
// ----------------------------------------------------------------------------
module nmea_sentence_check_classify_tb;

  localparam int MAX_LEN       = nsc_pkg::MAX_LEN_DEF;
  localparam int CHAR_TARGET   = 1450;
  localparam int BATCH_CHARS   = 240;
  localparam int WATCH_LIMIT   = 400;
  localparam int REPORT_LIMIT  = 10;

  // One character request toward the block
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_req_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] sentence_kind;
  logic       checksum_present;
  logic [7:0] computed_xor;

  nmea_sentence_check_classify #(
    .MAX_LEN(MAX_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sentence_kind(sentence_kind),
    .checksum_present(checksum_present),
    .computed_xor(computed_xor)
  );

  // Stimulus and scoreboard storage
  char_req_t         char_queue[$];
  nsc_pkg::result_t  verdicts_due[$];
  logic [7:0]        sbuf[$];

  // Bench copy of the scan state
  logic              strict_copy;
  nsc_pkg::phase_t   scan_phase;
  logic [7:0]        scan_xor;
  logic [3:0]        scan_hi;
  int                scan_count;
  logic [7:0]        scan_id[3];
  logic              scan_id_ok;
  logic              scan_star;
  logic              scan_bad;

  int          posted_chars;
  int          mismatches;
  int          quiet_cycles;
  int          send_gap;
  int          recv_gap;
  logic        fast_send;
  logic        fast_recv;
  logic        in_took;
  logic        out_took;

  logic [23:0] kind_ids[8] = '{"RMC", "GGA", "GSA", "GLL", "GST", "GSV", "VTG", "ZDA"};

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------
  function automatic logic is_text_char(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    return -1;
  endfunction

  task automatic clear_scan();
    scan_phase = nsc_pkg::PH_DOLLAR;
    scan_xor   = 8'h00;
    scan_hi    = 4'h0;
    scan_count = 0;
    scan_id[0] = 8'h00;
    scan_id[1] = 8'h00;
    scan_id[2] = 8'h00;
    scan_id_ok = 1'b1;
    scan_star  = 1'b0;
    scan_bad   = 1'b0;
  endtask

  task automatic scan_drop();
    scan_bad   = 1'b1;
    scan_phase = nsc_pkg::PH_ENDED;
  endtask

  // Only nothing, LF or CR LF may close the sentence
  task automatic scan_trailer(input logic [7:0] b);
    if (b == nsc_pkg::CH_LF) scan_phase = nsc_pkg::PH_LF;
    else if (b == nsc_pkg::CH_CR) scan_phase = nsc_pkg::PH_CR;
    else scan_drop();
  endtask

  // Advance the scan by one character; on the final one queue the verdict
  task automatic absorb_char(input logic [7:0] b, input logic fin);
    int               pos;
    int               h;
    logic             ok;
    nsc_pkg::result_t r;
    if (scan_phase != nsc_pkg::PH_ENDED) begin
      if (b == nsc_pkg::CH_NUL) begin
        // NUL ends the text; it fails where more text is required
        if (scan_phase == nsc_pkg::PH_DOLLAR || scan_phase == nsc_pkg::PH_HEX1 ||
            scan_phase == nsc_pkg::PH_HEX2 || scan_phase == nsc_pkg::PH_CR) begin
          scan_bad = 1'b1;
        end
        scan_phase = nsc_pkg::PH_ENDED;
      end else begin
        pos = scan_count;
        if (scan_count < MAX_LEN + 4) scan_count++;
        if (pos >= 1 && pos <= 5) begin
          if (!is_text_char(b) || b == nsc_pkg::CH_COMMA || b == nsc_pkg::CH_STAR) begin
            scan_id_ok = 1'b0;
          end
          if (pos >= 3) scan_id[pos - 3] = b;
        end
        case (scan_phase)
          nsc_pkg::PH_DOLLAR: begin
            if (b == nsc_pkg::CH_DOLLAR) scan_phase = nsc_pkg::PH_BODY;
            else scan_drop();
          end
          nsc_pkg::PH_BODY: begin
            if (b == nsc_pkg::CH_STAR) begin
              scan_star  = 1'b1;
              scan_phase = nsc_pkg::PH_HEX1;
            end else if (is_text_char(b)) begin
              scan_xor = scan_xor ^ b;
            end else begin
              scan_trailer(b);
            end
          end
          nsc_pkg::PH_HEX1: begin
            h = nibble_of(b);
            if (h < 0) begin
              scan_drop();
            end else begin
              scan_hi    = h[3:0];
              scan_phase = nsc_pkg::PH_HEX2;
            end
          end
          nsc_pkg::PH_HEX2: begin
            h = nibble_of(b);
            if (h < 0 || {scan_hi, h[3:0]} != scan_xor) scan_drop();
            else scan_phase = nsc_pkg::PH_TRAIL;
          end
          nsc_pkg::PH_TRAIL: scan_trailer(b);
          nsc_pkg::PH_CR: begin
            if (b == nsc_pkg::CH_LF) scan_phase = nsc_pkg::PH_LF;
            else scan_drop();
          end
          default: scan_drop();
        endcase
      end
    end
    if (fin) begin
      ok = !scan_bad && scan_id_ok && scan_count >= 6 && scan_count <= MAX_LEN + 3 &&
           scan_phase != nsc_pkg::PH_HEX1 && scan_phase != nsc_pkg::PH_HEX2 &&
           scan_phase != nsc_pkg::PH_CR && !(strict_copy && !scan_star);
      r.kind = nsc_pkg::KIND_INVALID;
      if (ok) begin
        r.kind = nsc_pkg::KIND_UNKNOWN;
        for (int k = 0; k < 8; k++) begin
          if ({scan_id[0], scan_id[1], scan_id[2]} == kind_ids[k]) begin
            r.kind = nsc_pkg::kind_t'(nsc_pkg::KIND_RMC + k);
          end
        end
      end
      r.star = scan_star;
      r.xsum = scan_xor;
      verdicts_due.push_back(r);
      clear_scan();
    end
  endtask

  // Compare one verdict with the oldest prediction
  task automatic check_verdict();
    nsc_pkg::result_t want;
    if (verdicts_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("unexpected verdict: kind %0d star %0b xor %02h",
                 sentence_kind, checksum_present, computed_xor);
      end
    end else begin
      want = verdicts_due.pop_front();
      if (sentence_kind != want.kind || checksum_present != want.star ||
          computed_xor != want.xsum) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display({"verdict mismatch: expected kind %0d star %0b xor %02h, ",
                    "got kind %0d star %0b xor %02h"},
                   want.kind, want.star, want.xsum,
                   sentence_kind, checksum_present, computed_xor);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sample both channels, run the model and the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_took      <= 1'b0;
      out_took     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took  <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready) absorb_char(data_byte, last_byte);
      if (out_valid && out_ready) check_verdict();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCH_LIMIT) begin
        $display("nmea_sentence_check_classify regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present character requests with a random gap after each
  always @(negedge clk) begin : drive_chars
    char_req_t nx;
    if (!rst) begin
      if (in_valid && !in_took) begin
        // hold the request until it is taken
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (char_queue.size() > 0) begin
        nx        = char_queue.pop_front();
        in_valid  <= 1'b1;
        data_byte <= nx.ch;
        last_byte <= nx.fin;
        send_gap  <= fast_send ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the verdict side for a random count after each verdict
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) recv_gap = fast_recv ? 0 : $urandom_range(0, 10);
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  = recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sentence builders
  // --------------------------------------------------------------------------
  task automatic put_text(input string t);
    for (int i = 0; i < t.len(); i++) sbuf.push_back(t[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 10) return 8'h30 + v;
    return 8'((lower ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // Append star and two hex digits over everything after the dollar
  task automatic add_checksum(input logic lower);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 1; i < sbuf.size(); i++) x = x ^ sbuf[i];
    sbuf.push_back(nsc_pkg::CH_STAR);
    sbuf.push_back(hex_char(x[7:4], lower));
    sbuf.push_back(hex_char(x[3:0], lower));
  endtask

  task automatic add_trailer(input int tail);
    if (tail == 2) sbuf.push_back(nsc_pkg::CH_CR);
    if (tail >= 1) sbuf.push_back(nsc_pkg::CH_LF);
  endtask

  // Move the built sentence into the request queue, flagging its final character
  task automatic post_sentence();
    char_req_t r;
    for (int i = 0; i < sbuf.size(); i++) begin
      r.ch  = sbuf[i];
      r.fin = (i == sbuf.size() - 1);
      char_queue.push_back(r);
      posted_chars++;
    end
    sbuf.delete();
  endtask

  // Well-formed sentence with random identifier, body and trailer
  task automatic compose_sentence(input int body_len, input logic with_star,
                                  input int tail, input logic lower);
    logic [23:0] tid;
    logic [7:0]  c;
    sbuf.delete();
    sbuf.push_back(nsc_pkg::CH_DOLLAR);
    case ($urandom_range(0, 4))
      0: put_text("GP");
      1: put_text("GN");
      2: put_text("GL");
      3: put_text("BD");
      default: begin
        sbuf.push_back(8'($urandom_range("A", "Z")));
        sbuf.push_back(8'($urandom_range("A", "Z")));
      end
    endcase
    if ($urandom_range(0, 4) != 0) begin
      tid = kind_ids[$urandom_range(0, 7)];
    end else begin
      tid = {8'($urandom_range("A", "Z")), 8'($urandom_range("A", "Z")),
             8'($urandom_range("A", "Z"))};
    end
    sbuf.push_back(tid[23:16]);
    sbuf.push_back(tid[15:8]);
    sbuf.push_back(tid[7:0]);
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        c = nsc_pkg::CH_COMMA;
      end else begin
        do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == nsc_pkg::CH_STAR);
      end
      sbuf.push_back(c);
    end
    if (with_star) add_checksum(lower);
    add_trailer(tail);
  endtask

  // Damage a built sentence in one of several ways
  task automatic spoil_sentence();
    int n;
    n = sbuf.size();
    case ($urandom_range(0, 7))
      0: sbuf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      1: sbuf.insert($urandom_range(0, n), nsc_pkg::CH_NUL);
      2: sbuf = sbuf[0:$urandom_range(0, n - 2)];
      3: sbuf[$urandom_range(1, 5)] = $urandom_range(0, 1) ? nsc_pkg::CH_COMMA
                                                            : nsc_pkg::CH_STAR;
      4: repeat ($urandom_range(1, 4)) sbuf.push_back(8'($urandom_range(0, 255)));
      5: sbuf.push_back(nsc_pkg::CH_CR);
      6: sbuf.insert($urandom_range(6, n), 8'($urandom_range(1, 8'h1F)));
      default: sbuf[$urandom_range(1, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
    endcase
  endtask

  // One random sentence: mostly well formed, some damaged, some noise
  task automatic random_sentence();
    int   pick;
    int   body_len;
    int   tail;
    logic with_star;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      sbuf.delete();
      if ($urandom_range(0, 1)) sbuf.push_back(nsc_pkg::CH_DOLLAR);
      repeat ($urandom_range(1, 12)) sbuf.push_back(8'($urandom_range(0, 255)));
    end else begin
      with_star = ($urandom_range(0, 9) < 7);
      tail      = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        // land near the length limit
        body_len = MAX_LEN + $urandom_range(0, 6) - 6 - (with_star ? 3 : 0) - tail;
        if (body_len < 0) body_len = 0;
      end else begin
        body_len = $urandom_range(0, 20);
      end
      compose_sentence(body_len, with_star, tail, $urandom_range(0, 1));
      if (pick < 35) spoil_sentence();
    end
    post_sentence();
  endtask

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic wait_idle();
    do @(posedge clk);
    while (char_queue.size() != 0 || in_valid || verdicts_due.size() != 0);
  endtask

  // Write strict mode once the block has drained
  task automatic set_strict(input logic v);
    wait_idle();
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    strict_copy = v;
  endtask

  initial begin
    int batch;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    data_byte    = 8'h00;
    last_byte    = 1'b0;
    out_ready    = 1'b0;
    strict_copy  = 1'b0;
    posted_chars = 0;
    mismatches   = 0;
    send_gap     = 0;
    recv_gap     = 0;
    fast_send    = 1'b0;
    fast_recv    = 1'b0;
    clear_scan();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: shortest valid sentence, NUL first, checksum with CR LF
    set_strict(1'b0);
    put_text("$GPGGA");
    post_sentence();
    sbuf.push_back(nsc_pkg::CH_NUL);
    post_sentence();
    put_text("$gpZDA");
    add_checksum(1'b1);
    add_trailer(2);
    post_sentence();

    // Directed: strict mode rejects a sentence without checksum
    set_strict(1'b1);
    put_text("$GPVTG");
    post_sentence();

    // Random batches, each with its own mode and idling profile
    batch = 0;
    while (posted_chars < CHAR_TARGET) begin
      set_strict(batch == 0 ? 1'b0 : logic'($urandom_range(0, 1)));
      fast_send = ($urandom_range(0, 3) == 0);
      fast_recv = ($urandom_range(0, 3) == 0);
      while (char_queue.size() < BATCH_CHARS && posted_chars < CHAR_TARGET) begin
        random_sentence();
      end
      wait_idle();
      batch++;
    end

    // Drain and let any late verdict show up
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("nmea_sentence_check_classify regression: pass");
    end else begin
      $display("nmea_sentence_check_classify regression: fail");
    end
    $finish;
  end

endmodule
